// File: design/ppti_pkg.sv
// ----------------------------------------------------------------------------
// ppti_pkg
// Shared types and constants for the tabulated pair potential interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package ppti_pkg;

	localparam int TABLE_SIZE_C = 4096;
	localparam int PAIR_TYPES_C = 3;

	localparam int SMP_W  = 32;   // Q16.16 sample / potential
	localparam int DIST_W = 24;   // Q8.16 squared distance
	localparam int STEP_W = 32;   // Q16.16 inverse step
	localparam int FRAC_W = 16;   // weight bits kept

	localparam logic [16:0] ONE_Q16  = 17'h10000;   // 1.0
	localparam logic [15:0] HALF_Q16 = 16'h8000;    // 0.5, rounding

	typedef enum logic [1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_SAMPLE = 2'd1,
		REQ_BOUNDS = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		RGN_INTERP = 2'd0,
		RGN_BELOW  = 2'd1,
		RGN_BEYOND = 2'd2,
		RGN_WRITE  = 2'd3
	} region_t;

	// load enables for the back half of the pipeline
	typedef struct packed {
		logic ld4;
		logic ld5;
		logic ld6;
		logic ldo;
	} ppti_adv_t;

endpackage

`default_nettype wire

// File: design/ppti_mem.sv
// ----------------------------------------------------------------------------
// ppti_mem
// Sample store: two identical copies, one write port, three registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module ppti_mem import ppti_pkg::*; #(
	parameter int DEPTH  = TABLE_SIZE_C * PAIR_TYPES_C,
	parameter int ADDR_W = $clog2(TABLE_SIZE_C * PAIR_TYPES_C)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [SMP_W-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr0,
	input  wire logic [ADDR_W-1:0] raddr1,
	input  wire logic [ADDR_W-1:0] raddr2,
	output logic      [SMP_W-1:0]  rdata0,
	output logic      [SMP_W-1:0]  rdata1,
	output logic      [SMP_W-1:0]  rdata2
);

	// copy a serves entries bin and bin+1, copy b serves bin+2
	logic [SMP_W-1:0] mem_a [DEPTH];
	logic [SMP_W-1:0] mem_b [DEPTH];

	logic [SMP_W-1:0] rd0_q, rd1_q, rd2_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_a[waddr] <= wdata;
			mem_b[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd0_q <= mem_a[raddr0];
			rd1_q <= mem_a[raddr1];
			rd2_q <= mem_b[raddr2];
		end
	end

	assign rdata0 = rd0_q;
	assign rdata1 = rd1_q;
	assign rdata2 = rd2_q;

endmodule

`default_nettype wire

// File: design/ppti_interp.sv
// ----------------------------------------------------------------------------
// ppti_interp
// Newton-Gregory datapath: differences, products, sum, round and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module ppti_interp import ppti_pkg::*; (
	input  wire logic             clk,
	input  wire ppti_adv_t        adv,
	input  wire logic [SMP_W-1:0] v0,
	input  wire logic [SMP_W-1:0] v1,
	input  wire logic [SMP_W-1:0] v2,
	input  wire logic [15:0]      w_s3,
	input  wire logic [30:0]      c_s3,
	input  wire region_t          region_s3,
	output logic signed [SMP_W-1:0] potential,
	output logic [1:0]            region
);

	logic [32:0]        d1_s4;
	logic [33:0]        d2_s4;
	logic [SMP_W-1:0]   v0_s4, v0_s5, v0_s6;
	logic [15:0]        w_s4;
	logic [30:0]        c_s4;
	region_t            region_s4, region_s5, region_s6;

	logic signed [49:0] p1_s5;
	logic signed [65:0] p2_s5;
	logic [51:0]        acc_s6;

	logic [51:0]        rnd;
	logic [35:0]        quo;
	logic [SMP_W-1:0]   sat;

	logic [SMP_W-1:0]   pot_q;
	region_t            region_q;

	// stage 4: first and second differences
	always_ff @(posedge clk) begin
		if (adv.ld4) begin
			d1_s4     <= {v1[31], v1} - {v0[31], v0};
			d2_s4     <= {{2{v2[31]}}, v2} - {v1[31], v1, 1'b0} + {{2{v0[31]}}, v0};
			v0_s4     <= v0;
			w_s4      <= w_s3;
			c_s4      <= c_s3;
			region_s4 <= region_s3;
		end
	end

	// stage 5: d1*w and d2*w*(1-w)
	always_ff @(posedge clk) begin
		if (adv.ld5) begin
			p1_s5     <= $signed(d1_s4) * $signed({1'b0, w_s4});
			p2_s5     <= $signed(d2_s4) * $signed({1'b0, c_s4});
			v0_s5     <= v0_s4;
			region_s5 <= region_s4;
		end
	end

	// stage 6: acc = v0*2^16 + d1*w - floor(d2*c / 2^17)
	always_ff @(posedge clk) begin
		if (adv.ld6) begin
			acc_s6    <= {{4{v0_s5[31]}}, v0_s5, 16'h0000}
				+ {{2{p1_s5[49]}}, p1_s5}
				- {{3{p2_s5[65]}}, p2_s5[65:17]};
			v0_s6     <= v0_s5;
			region_s6 <= region_s5;
		end
	end

	// round half up, then clip to 32 bits
	always_comb begin
		rnd = acc_s6 + {36'd0, HALF_Q16};
		quo = rnd[51:16];
		if (!quo[35] && (|quo[34:31])) begin
			sat = {1'b0, {(SMP_W-1){1'b1}}};
		end else if (quo[35] && !(&quo[34:31])) begin
			sat = {1'b1, {(SMP_W-1){1'b0}}};
		end else begin
			sat = quo[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv.ldo) begin
			region_q <= region_s6;
			case (region_s6)
				RGN_INTERP: pot_q <= sat;
				RGN_BELOW:  pot_q <= v0_s6;
				default:    pot_q <= '0;
			endcase
		end
	end

	assign potential = $signed(pot_q);
	assign region    = region_q;

endmodule

`default_nettype wire

// File: design/pair_potential_table_interp.sv
// ----------------------------------------------------------------------------
// pair_potential_table_interp: one word per cycle while out_ready keeps the output moving.
// Seven register stages; three table reads per cycle come from two memory copies.
// Reset clears valid bits and bounds; the sample table is undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module pair_potential_table_interp import ppti_pkg::*; #(
	parameter int TABLE_SIZE = TABLE_SIZE_C,
	parameter int PAIR_TYPES = PAIR_TYPES_C
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [1:0]               req_type,
	input  wire logic [1:0]               pair_type,
	input  wire logic [DIST_W-1:0]        sq_distance,
	input  wire logic [11:0]              table_index,
	input  wire logic signed [SMP_W-1:0]  sample_value,
	input  wire logic [DIST_W-1:0]        bound_min,
	input  wire logic [DIST_W-1:0]        bound_cut,
	input  wire logic [STEP_W-1:0]        inverse_step,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [SMP_W-1:0]       potential,
	output logic [1:0]                    region
);

	// Pipeline
	//   accept : bounds lookup, region decision, rsq - min
	//   s1->s2 : (rsq - min) * inverse_step, 24x32
	//   s2->s3 : bin/weight split, index clamp, memory read or sample write,
	//            c = w*(1-w)
	//   s3..out: differences, products, sum, round/saturate (ppti_interp)
	// Every stage has its own valid bit and loads when empty or when its word
	// moves on, so bubbles collapse and a stalled output only backs up once
	// the whole pipe is full. Sample writes commit at the same stage where
	// lookups read, so program order is kept without forwarding. Bounds are
	// written and read at accept, likewise in order.

	localparam int IDX_W  = $clog2(TABLE_SIZE);
	localparam int DEPTH  = PAIR_TYPES * TABLE_SIZE;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int TSEL_W = (PAIR_TYPES > 1) ? $clog2(PAIR_TYPES) : 1;
	localparam logic [3:0]  NUM_TYPES = 4'(PAIR_TYPES);
	localparam logic [16:0] TBL_SIZE  = 17'(TABLE_SIZE);
	localparam logic [24:0] LAST_IDX  = 25'(TABLE_SIZE - 1);

	// ---- handshake and stage valids ---------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, out_vld_q;
	logic load_1, load_2, load_3, load_4, load_5, load_6, load_o;
	logic accept;
	ppti_adv_t adv;

	assign load_o = !out_vld_q || out_ready;
	assign load_6 = !vld_s6 || load_o;
	assign load_5 = !vld_s5 || load_6;
	assign load_4 = !vld_s4 || load_5;
	assign load_3 = !vld_s3 || load_4;
	assign load_2 = !vld_s2 || load_3;
	assign load_1 = !vld_s1 || load_2;

	assign in_ready  = load_1;
	assign accept    = in_valid && load_1;
	assign out_valid = out_vld_q;

	assign adv = '{ld4: load_4, ld5: load_5, ld6: load_6, ldo: load_o};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (load_1) vld_s1 <= in_valid;
			if (load_2) vld_s2 <= vld_s1;
			if (load_3) vld_s3 <= vld_s2;
			if (load_4) vld_s4 <= vld_s3;
			if (load_5) vld_s5 <= vld_s4;
			if (load_6) vld_s6 <= vld_s5;
			if (load_o) out_vld_q <= vld_s6;
		end
	end

	// ---- per-type bounds ---------------------------------------------------
	logic [DIST_W-1:0] min_q  [PAIR_TYPES];
	logic [DIST_W-1:0] cut_q  [PAIR_TYPES];
	logic [STEP_W-1:0] step_q [PAIR_TYPES];

	logic [3:0]        type_ext;
	logic [TSEL_W-1:0] type_sel;
	logic              type_ok;
	req_t              req;

	assign type_ext = {2'b00, pair_type};
	assign type_sel = type_ext[TSEL_W-1:0];
	assign type_ok  = type_ext < NUM_TYPES;
	assign req      = req_t'(req_type);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAIR_TYPES; i++) begin
				min_q[i]  <= '0;
				cut_q[i]  <= '0;
				step_q[i] <= '0;
			end
		end else if (accept && req == REQ_BOUNDS && type_ok) begin
			min_q[type_sel]  <= bound_min;
			cut_q[type_sel]  <= bound_cut;
			step_q[type_sel] <= inverse_step;
		end
	end

	// ---- accept stage: region decision -------------------------------------
	logic [DIST_W-1:0] min_sel, cut_sel;
	logic [STEP_W-1:0] step_sel;
	region_t           region_in;
	logic [16:0]       tidx_ext;
	logic              tidx_ok;

	assign min_sel  = type_ok ? min_q[type_sel]  : '0;
	assign cut_sel  = type_ok ? cut_q[type_sel]  : '0;
	assign step_sel = type_ok ? step_q[type_sel] : '0;
	assign tidx_ext = {5'd0, table_index};
	assign tidx_ok  = tidx_ext < TBL_SIZE;

	// cutoff is tested first: with min >= cut, rsq >= cut is still beyond-cutoff
	always_comb begin
		case (req)
			REQ_LOOKUP: begin
				if (!type_ok || sq_distance >= cut_sel) begin
					region_in = RGN_BEYOND;
				end else if (sq_distance <= min_sel) begin
					region_in = RGN_BELOW;
				end else begin
					region_in = RGN_INTERP;
				end
			end
			default: region_in = RGN_WRITE;
		endcase
	end

	// ---- s1 ----------------------------------------------------------------
	region_t           region_s1, region_s2, region_s3;
	logic [DIST_W-1:0] diff_s1;
	logic [STEP_W-1:0] step_s1;
	logic              wr_s1, wr_s2;
	logic [TSEL_W-1:0] type_s1, type_s2;
	logic [IDX_W-1:0]  tidx_s1, tidx_s2;
	logic [SMP_W-1:0]  sval_s1, sval_s2;

	always_ff @(posedge clk) begin
		if (load_1) begin
			region_s1 <= region_in;
			diff_s1   <= sq_distance - min_sel;  // only used when rsq > min
			step_s1   <= step_sel;
			wr_s1     <= (req == REQ_SAMPLE) && type_ok && tidx_ok;
			type_s1   <= type_sel;
			tidx_s1   <= tidx_ext[IDX_W-1:0];
			sval_s1   <= sample_value;
		end
	end

	// ---- s2: exact Q24.32 product ------------------------------------------
	logic [55:0] prod_s2;

	always_ff @(posedge clk) begin
		if (load_2) begin
			prod_s2   <= 56'(diff_s1) * 56'(step_s1);
			region_s2 <= region_s1;
			wr_s2     <= wr_s1;
			type_s2   <= type_s1;
			tidx_s2   <= tidx_s1;
			sval_s2   <= sval_s1;
		end
	end

	// ---- s2 logic: bin, weight, clamped addresses --------------------------
	logic [23:0]       bin;
	logic [15:0]       w;
	logic [24:0]       bin_p0, bin_p1, bin_p2;
	logic [IDX_W-1:0]  idx0, idx1, idx2;
	logic [ADDR_W-1:0] base, raddr0, raddr1, raddr2, waddr;
	logic [32:0]       c_full;

	assign bin    = prod_s2[55:32];
	assign w      = prod_s2[31:16];
	assign bin_p0 = {1'b0, bin};
	assign bin_p1 = {1'b0, bin} + 25'd1;
	assign bin_p2 = {1'b0, bin} + 25'd2;

	// entries past the table end all read the last sample;
	// below-minimum answers entry 0
	always_comb begin
		idx0 = (bin_p0 >= LAST_IDX) ? LAST_IDX[IDX_W-1:0] : bin_p0[IDX_W-1:0];
		idx1 = (bin_p1 >= LAST_IDX) ? LAST_IDX[IDX_W-1:0] : bin_p1[IDX_W-1:0];
		idx2 = (bin_p2 >= LAST_IDX) ? LAST_IDX[IDX_W-1:0] : bin_p2[IDX_W-1:0];
		if (region_s2 == RGN_BELOW) begin
			idx0 = '0;
		end
	end

	assign base   = ADDR_W'(type_s2) * ADDR_W'(TABLE_SIZE);
	assign raddr0 = base + ADDR_W'(idx0);
	assign raddr1 = base + ADDR_W'(idx1);
	assign raddr2 = base + ADDR_W'(idx2);
	assign waddr  = base + ADDR_W'(tidx_s2);

	// c = w * (1 - w), at most 2^30
	assign c_full = 33'(w) * 33'(ONE_Q16 - {1'b0, w});

	logic [15:0] w_s3;
	logic [30:0] c_s3;

	always_ff @(posedge clk) begin
		if (load_3) begin
			w_s3      <= w;
			c_s3      <= c_full[30:0];
			region_s3 <= region_s2;
		end
	end

	// ---- sample memory -----------------------------------------------------
	logic             mem_we;
	logic [SMP_W-1:0] v0, v1, v2;

	assign mem_we = load_3 && vld_s2 && wr_s2;

	ppti_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (waddr),
		.wdata  (sval_s2),
		.re     (load_3),
		.raddr0 (raddr0),
		.raddr1 (raddr1),
		.raddr2 (raddr2),
		.rdata0 (v0),
		.rdata1 (v1),
		.rdata2 (v2)
	);

	// ---- interpolation back end --------------------------------------------
	ppti_interp u_interp (
		.clk       (clk),
		.adv       (adv),
		.v0        (v0),
		.v1        (v1),
		.v2        (v2),
		.w_s3      (w_s3),
		.c_s3      (c_s3),
		.region_s3 (region_s3),
		.potential (potential),
		.region    (region)
	);

`ifndef SYNTH
	// input only backs up once every stage holds a word
	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6
			&& out_vld_q))
		else $error("input stalled with a bubble in the pipe");

	// writes and out-of-range answers carry zero potential
	a_zero_potential: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (region == RGN_WRITE || region == RGN_BEYOND) |-> potential == '0)
		else $error("nonzero potential on write or cutoff word");

	// a lookup for an unknown pair type is classed beyond cutoff
	a_bad_type: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req == REQ_LOOKUP && !type_ok |=> region_s1 == RGN_BEYOND)
		else $error("unknown pair type not classed beyond cutoff");

	// a sample write only commits for a valid word
	a_write_valid: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> vld_s2 && region_s2 == RGN_WRITE)
		else $error("sample write from a non-write word");
`endif

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pair_potential_table_interp. A directed table of
// words comes first, then random traffic. Every result is checked in order:
// typed rows against a hand answer, the rest against a cycle-free model of
// the sample tables, the per-type bounds and the three-point interpolation.
// ----------------------------------------------------------------------------

module testbench;
	import ppti_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;   // far above the slowest legal run
	localparam int DRAIN_CYCLES = 30;       // pipeline is 7 deep
	localparam int RAND_WORDS   = 420;      // after the table fill
	localparam int HOLD_CYCLES  = 80;       // long receiver hold-off
	localparam int QUIET_LO     = 250;      // words/results in [LO,HI) run with
	localparam int QUIET_HI     = 350;      // no idling on either side
	localparam longint SAT_HI   = 64'sd2147483647;
	localparam longint SAT_LO   = -64'sd2147483648;

	typedef struct {
		req_t        req;
		logic [1:0]  ptype;
		logic [23:0] rsq;
		logic [11:0] idx;
		logic [31:0] sval;
		logic [23:0] bmin;
		logic [23:0] bcut;
		logic [31:0] istep;
	} word_t;

	typedef struct {
		logic signed [31:0] pot;
		region_t            rgn;
	} result_t;

	// one line of the directed part; 'typed' rows carry a hand-written answer
	typedef struct {
		word_t   w;
		bit      typed;
		result_t res;
	} dir_row_t;

	// ------------------------------------------------------------------
	// DUT ports, all inputs known from time zero
	// ------------------------------------------------------------------
	logic               clk;
	logic               arst_n       = 1'b0;
	logic               in_valid     = 1'b0;
	logic               in_ready;
	logic [1:0]         req_type     = '0;
	logic [1:0]         pair_type    = '0;
	logic [23:0]        sq_distance  = '0;
	logic [11:0]        table_index  = '0;
	logic signed [31:0] sample_value = '0;
	logic [23:0]        bound_min    = '0;
	logic [23:0]        bound_cut    = '0;
	logic [31:0]        inverse_step = '0;
	logic               out_valid;
	logic               out_ready    = 1'b0;
	logic signed [31:0] potential;
	logic [1:0]         region;

	pair_potential_table_interp dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.pair_type   (pair_type),
		.sq_distance (sq_distance),
		.table_index (table_index),
		.sample_value(sample_value),
		.bound_min   (bound_min),
		.bound_cut   (bound_cut),
		.inverse_step(inverse_step),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.potential   (potential),
		.region      (region)
	);

	// ------------------------------------------------------------------
	// Model state: mirrors the block after every accepted word.
	// 'written' tracks which samples hold data so that no lookup ever
	// touches an entry that was never loaded.
	// ------------------------------------------------------------------
	logic [31:0] smp_mem  [PAIR_TYPES_C][TABLE_SIZE_C];
	bit          written  [PAIR_TYPES_C][TABLE_SIZE_C];
	logic [23:0] lo_bound [PAIR_TYPES_C];
	logic [23:0] cut_bound[PAIR_TYPES_C];
	logic [31:0] step_q16 [PAIR_TYPES_C];

	result_t     pending_results[$];
	dir_row_t    directed_words[$];
	result_t     head_result;
	int unsigned mismatches   = 0;
	int unsigned cycle_no     = 0;
	int unsigned words_in     = 0;
	int unsigned results_seen = 0;
	int unsigned hold_left    = 0;
	int unsigned next_hold    = 100;

	function automatic int clamp_idx(input logic [63:0] i);
		return (i > TABLE_SIZE_C - 1) ? TABLE_SIZE_C - 1 : int'(i);
	endfunction

	function automatic longint sample_at(input int t, input logic [63:0] i);
		return longint'(signed'(smp_mem[t][clamp_idx(i)]));
	endfunction

	// (rsq - min) * inverse_step, exact: bin in 63..32, weight in 31..16
	function automatic logic [63:0] distance_product(input int t, input logic [23:0] rsq);
		return (64'(rsq) - 64'(lo_bound[t])) * 64'(step_q16[t]);
	endfunction

	// Apply one word to the model state and return the result it produces.
	function automatic result_t evaluate_word(input word_t w);
		result_t     r;
		int          t;
		logic [63:0] prod;
		logic [63:0] bin;
		longint      wt, v0, v1, v2, d1, d2, c, acc, p;
		r.pot = '0;
		r.rgn = RGN_WRITE;
		t = int'(w.ptype);
		case (w.req)
		REQ_SAMPLE: begin
			if (t < PAIR_TYPES_C) begin
				smp_mem[t][w.idx] = w.sval;
				written[t][w.idx] = 1'b1;
			end
		end
		REQ_BOUNDS: begin
			if (t < PAIR_TYPES_C) begin
				lo_bound[t]  = w.bmin;
				cut_bound[t] = w.bcut;
				step_q16[t]  = w.istep;
			end
		end
		REQ_LOOKUP: begin
			// cutoff is tested first: with min >= cut, rsq >= cut still answers "beyond"
			if (t >= PAIR_TYPES_C) begin
				r.rgn = RGN_BEYOND;
			end else if (w.rsq >= cut_bound[t]) begin
				r.rgn = RGN_BEYOND;
			end else if (w.rsq <= lo_bound[t]) begin
				r.rgn = RGN_BELOW;
				r.pot = smp_mem[t][0];
			end else begin
				prod = distance_product(t, w.rsq);
				bin  = prod >> 32;
				wt   = longint'(prod[31:16]);
				v0   = sample_at(t, bin);
				v1   = sample_at(t, bin + 1);
				v2   = sample_at(t, bin + 2);
				d1   = v1 - v0;
				d2   = v2 - 2 * v1 + v0;
				c    = wt * (65536 - wt);
				// >>> on signed operands floors, as the p2 slice in ppti_interp stage 6 does
				acc  = v0 * 65536 + d1 * wt - ((d2 * c) >>> 17);
				p    = (acc + 32768) >>> 16;
				if (p > SAT_HI)
					p = SAT_HI;
				if (p < SAT_LO)
					p = SAT_LO;
				r.pot = p[31:0];
				r.rgn = RGN_INTERP;
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	// True when a lookup only reads samples that were loaded.
	function automatic bit lookup_safe(input int t, input logic [23:0] rsq);
		logic [63:0] bin;
		if (t >= PAIR_TYPES_C)
			return 1'b1;
		if (rsq >= cut_bound[t])
			return 1'b1;
		if (rsq <= lo_bound[t])
			return written[t][0];
		bin = distance_product(t, rsq) >> 32;
		return written[t][clamp_idx(bin)] && written[t][clamp_idx(bin + 1)] &&
			written[t][clamp_idx(bin + 2)];
	endfunction

	// ------------------------------------------------------------------
	// Random word builders. Unused fields stay random so every input bit
	// toggles.
	// ------------------------------------------------------------------
	function automatic word_t noise_word();
		word_t w;
		w.req   = req_t'($urandom_range(0, 3));
		w.ptype = 2'($urandom);
		w.rsq   = 24'($urandom);
		w.idx   = 12'($urandom);
		w.sval  = $urandom;
		w.bmin  = 24'($urandom);
		w.bcut  = 24'($urandom);
		w.istep = $urandom;
		return w;
	endfunction

	// mostly valid types, now and then the unused fourth code
	function automatic logic [1:0] pick_type();
		return ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, PAIR_TYPES_C - 1));
	endfunction

	// Mostly aim at a chosen bin: low bins that the fill loaded, or the table end.
	function automatic logic [23:0] pick_distance(input int t);
		logic [63:0] tgt, diff;
		logic [23:0] lo, hi;
		lo = lo_bound[t];
		hi = cut_bound[t];
		case ($urandom_range(0, 9))
		0: return 24'($urandom);
		1: begin
			case ($urandom_range(0, 3))
			0:       return lo;
			1:       return hi;
			2:       return lo + 24'd1;
			default: return hi - 24'd1;
			endcase
		end
		default: begin
			if (step_q16[t] == 0)
				return lo + 24'($urandom_range(1, 255));
			tgt = ($urandom_range(0, 3) == 0) ?
				64'(TABLE_SIZE_C - 3 + $urandom_range(0, 4)) : 64'($urandom_range(0, 13));
			tgt  = (tgt << 32) | 64'($urandom);
			diff = tgt / 64'(step_q16[t]);
			if (64'(lo) + diff > 64'hFFFFFF)
				return 24'($urandom);
			return lo + diff[23:0];
		end
		endcase
	endfunction

	function automatic word_t lookup_word(input logic [1:0] t);
		word_t w;
		bit    ok;
		w       = noise_word();
		w.req   = REQ_LOOKUP;
		w.ptype = t;
		ok      = 1'b0;
		for (int k = 0; k < 8 && !ok; k++) begin
			w.rsq = (t >= PAIR_TYPES_C) ? 24'($urandom) : pick_distance(int'(t));
			ok    = lookup_safe(int'(t), w.rsq);
		end
		// all-ones is always at or past the cutoff
		if (!ok)
			w.rsq = '1;
		return w;
	endfunction

	function automatic word_t sample_word();
		word_t w;
		int    r;
		w       = noise_word();
		w.req   = REQ_SAMPLE;
		w.ptype = pick_type();
		r       = $urandom_range(0, 19);
		if (r < 14)
			w.idx = 12'($urandom_range(0, 15));
		else if (r < 17)
			w.idx = 12'($urandom_range(TABLE_SIZE_C - 6, TABLE_SIZE_C - 1));
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
			0:       w.sval = 32'h7FFF_FFFF;
			1:       w.sval = 32'h8000_0000;
			2:       w.sval = 32'h0000_0000;
			default: w.sval = 32'hFFFF_FFFF;
			endcase
		end
		return w;
	endfunction

	function automatic word_t bounds_word();
		word_t       w;
		logic [63:0] span, q;
		w       = noise_word();
		w.req   = REQ_BOUNDS;
		w.ptype = pick_type();
		case ($urandom_range(0, 9))
		0: begin
			// inverted bounds: min at or above cut
			w.bcut = 24'($urandom);
			w.bmin = 24'($urandom_range(int'(w.bcut), 24'hFFFFFF));
		end
		1: begin
			w.bmin = '0;
			w.bcut = '1;
			case ($urandom_range(0, 2))
			0:       w.istep = '0;
			1:       w.istep = '1;
			default: w.istep = $urandom;
			endcase
		end
		default: begin
			// span and step chosen so that most bins land in the loaded window
			w.bmin  = 24'($urandom_range(0, 24'h3FFFFF));
			span    = 64'($urandom_range(1, 24'h0FFFFF));
			w.bcut  = w.bmin + span[23:0];
			q       = (64'($urandom_range(1, 13)) << 32) / span;
			w.istep = (q > 64'hFFFF_FFFF) ? '1 : q[31:0];
		end
		endcase
		return w;
	endfunction

	function automatic dir_row_t dir_row(input req_t rq, input logic [1:0] t,
			input logic [23:0] rsq, input logic [11:0] idx, input logic [31:0] sval,
			input logic [23:0] bmin, input logic [23:0] bcut, input logic [31:0] st,
			input bit typed, input logic [31:0] pot, input region_t rgn);
		dir_row_t d;
		d.w       = '{rq, t, rsq, idx, sval, bmin, bcut, st};
		d.typed   = typed;
		d.res.pot = pot;
		d.res.rgn = rgn;
		return d;
	endfunction

	// ------------------------------------------------------------------
	// Clock, cycle count and timeout
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
	end

	initial begin
		wait (cycle_no >= CYCLE_LIMIT);
		$display("TIMEOUT at cycle %0d, %0d results still due", cycle_no,
			pending_results.size());
		$display("Verification failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH cycle %0d: %s", cycle_no, msg);
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// Sender: idles in ~6% of cycles outside the quiet window, holds each
	// word until accepted, then updates the model on acceptance.
	// ------------------------------------------------------------------
	task automatic send_word(input word_t w, input bit typed, input result_t typed_res);
		result_t r;
		while (!(words_in >= QUIET_LO && words_in < QUIET_HI) && $urandom_range(0, 99) < 6) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= w.req;
		pair_type    <= w.ptype;
		sq_distance  <= w.rsq;
		table_index  <= w.idx;
		sample_value <= w.sval;
		bound_min    <= w.bmin;
		bound_cut    <= w.bcut;
		inverse_step <= w.istep;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		// model always advances; typed rows replace its answer by the hand one
		r = evaluate_word(w);
		pending_results.push_back(typed ? typed_res : r);
		words_in++;
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stalls, a quiet window, and two long hold-offs that
	// back the pipe up into the input side.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			results_seen <= results_seen + 1;
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (results_seen >= next_hold) begin
			hold_left <= HOLD_CYCLES;
			next_hold <= next_hold + 300;
			out_ready <= 1'b0;
		end else begin
			out_ready <= (results_seen >= QUIET_LO && results_seen < QUIET_HI) ||
				($urandom_range(0, 99) >= 6);
		end
	end

	// ------------------------------------------------------------------
	// Result check: in order, field by field
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected word pot=%h region=%0d", potential, region));
			end else begin
				head_result = pending_results.pop_front();
				if (potential !== head_result.pot)
					report_mismatch($sformatf("potential %h, want %h", potential,
						head_result.pot));
				if (region !== head_result.rgn)
					report_mismatch($sformatf("region %0d, want %s", region,
						head_result.rgn.name()));
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		word_t   w;
		result_t none_res;
		int      r;
		none_res.pot = '0;
		none_res.rgn = RGN_WRITE;
		for (int t = 0; t < PAIR_TYPES_C; t++) begin
			lo_bound[t]  = '0;
			cut_bound[t] = '0;
			step_q16[t]  = '0;
			for (int i = 0; i < TABLE_SIZE_C; i++)
				written[t][i] = 1'b0;
		end

		// Directed table. Type 0 gets samples at extremes so that the
		// interpolation swings to the ends of its range; type 1 gets inverted bounds.
		//                          req         t  rsq          idx      sval          min          cut          step          typed pot           region
		directed_words.push_back(dir_row(REQ_LOOKUP, 0, 24'h000000, 12'h000, 32'h0,        24'h0,       24'h0,       32'h0,        1, 32'h0,        RGN_BEYOND)); // cut is 0 after reset
		directed_words.push_back(dir_row(REQ_LOOKUP, 3, 24'h800000, 12'h000, 32'h0,        24'h0,       24'h0,       32'h0,        1, 32'h0,        RGN_BEYOND)); // bad pair type
		directed_words.push_back(dir_row(REQ_NONE,   1, 24'hFFFFFF, 12'hFFF, 32'hFFFFFFFF, 24'hFFFFFF,  24'hFFFFFF,  32'hFFFFFFFF, 1, 32'h0,        RGN_WRITE));  // unknown request
		directed_words.push_back(dir_row(REQ_SAMPLE, 0, 24'h0,      12'h000, 32'h7FFFFFFF, 24'h0,       24'h0,       32'h0,        1, 32'h0,        RGN_WRITE));
		directed_words.push_back(dir_row(REQ_SAMPLE, 0, 24'h0,      12'h001, 32'h80000000, 24'h0,       24'h0,       32'h0,        1, 32'h0,        RGN_WRITE));
		directed_words.push_back(dir_row(REQ_SAMPLE, 0, 24'h0,      12'h002, 32'h7FFFFFFF, 24'h0,       24'h0,       32'h0,        1, 32'h0,        RGN_WRITE));
		directed_words.push_back(dir_row(REQ_SAMPLE, 0, 24'h0,      12'hFFF, 32'hFFFFFFFF, 24'h0,       24'h0,       32'h0,        1, 32'h0,        RGN_WRITE));  // last entry
		directed_words.push_back(dir_row(REQ_SAMPLE, 3, 24'h0,      12'h000, 32'h12345678, 24'h0,       24'h0,       32'h0,        1, 32'h0,        RGN_WRITE));  // dropped
		directed_words.push_back(dir_row(REQ_BOUNDS, 0, 24'h0,      12'h000, 32'h0,        24'h010000,  24'h020000,  32'h00010000, 1, 32'h0,        RGN_WRITE));  // 1.0 .. 2.0
		directed_words.push_back(dir_row(REQ_LOOKUP, 0, 24'h010000, 12'h000, 32'h0,        24'h0,       24'h0,       32'h0,        1, 32'h7FFFFFFF, RGN_BELOW));  // rsq == min
		directed_words.push_back(dir_row(REQ_LOOKUP, 0, 24'h000000, 12'h000, 32'h0,        24'h0,       24'h0,       32'h0,        1, 32'h7FFFFFFF, RGN_BELOW));
		directed_words.push_back(dir_row(REQ_LOOKUP, 0, 24'h020000, 12'h000, 32'h0,        24'h0,       24'h0,       32'h0,        1, 32'h0,        RGN_BEYOND)); // rsq == cut
		directed_words.push_back(dir_row(REQ_LOOKUP, 0, 24'hFFFFFF, 12'h000, 32'h0,        24'h0,       24'h0,       32'h0,        1, 32'h0,        RGN_BEYOND));
		directed_words.push_back(dir_row(REQ_LOOKUP, 0, 24'h010001, 12'h000, 32'h0,        24'h0,       24'h0,       32'h0,        0, 32'h0,        RGN_INTERP)); // tiny weight
		directed_words.push_back(dir_row(REQ_LOOKUP, 0, 24'h018000, 12'h000, 32'h0,        24'h0,       24'h0,       32'h0,        0, 32'h0,        RGN_INTERP)); // half weight
		directed_words.push_back(dir_row(REQ_LOOKUP, 0, 24'h01FFFF, 12'h000, 32'h0,        24'h0,       24'h0,       32'h0,        0, 32'h0,        RGN_INTERP)); // weight near 1
		directed_words.push_back(dir_row(REQ_BOUNDS, 0, 24'h0,      12'h000, 32'h0,        24'h000000,  24'hFFFFFF,  32'hFFFFFFFF, 1, 32'h0,        RGN_WRITE));  // widest
		directed_words.push_back(dir_row(REQ_LOOKUP, 0, 24'hFFFFFE, 12'h000, 32'h0,        24'h0,       24'h0,       32'h0,        0, 32'h0,        RGN_INTERP)); // bins clamp
		directed_words.push_back(dir_row(REQ_LOOKUP, 0, 24'h000000, 12'h000, 32'h0,        24'h0,       24'h0,       32'h0,        1, 32'h7FFFFFFF, RGN_BELOW));  // rsq == min == 0
		directed_words.push_back(dir_row(REQ_SAMPLE, 1, 24'h0,      12'h000, 32'h00010000, 24'h0,       24'h0,       32'h0,        1, 32'h0,        RGN_WRITE));
		directed_words.push_back(dir_row(REQ_BOUNDS, 1, 24'h0,      12'h000, 32'h0,        24'h000100,  24'h000050,  32'h00010000, 1, 32'h0,        RGN_WRITE));  // min above cut
		directed_words.push_back(dir_row(REQ_LOOKUP, 1, 24'h000080, 12'h000, 32'h0,        24'h0,       24'h0,       32'h0,        1, 32'h0,        RGN_BEYOND)); // cut wins
		directed_words.push_back(dir_row(REQ_LOOKUP, 1, 24'h000050, 12'h000, 32'h0,        24'h0,       24'h0,       32'h0,        1, 32'h0,        RGN_BEYOND));
		directed_words.push_back(dir_row(REQ_LOOKUP, 1, 24'h000010, 12'h000, 32'h0,        24'h0,       24'h0,       32'h0,        1, 32'h00010000, RGN_BELOW));
		directed_words.push_back(dir_row(REQ_LOOKUP, 2, 24'h000000, 12'h000, 32'h0,        24'h0,       24'h0,       32'h0,        1, 32'h0,        RGN_BEYOND));

		// reset once, released on an edge
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_words[i])
			send_word(directed_words[i].w, directed_words[i].typed, directed_words[i].res);

		// load a window at both ends of every type's table
		for (int t = 0; t < PAIR_TYPES_C; t++) begin
			for (int k = 0; k < 19; k++) begin
				w       = sample_word();
				w.ptype = 2'(t);
				w.idx   = (k < 16) ? 12'(k) : 12'(TABLE_SIZE_C - 19 + k);
				send_word(w, 1'b0, none_res);
			end
		end

		// mixed traffic, mostly lookups
		for (int n = 0; n < RAND_WORDS; n++) begin
			r = $urandom_range(0, 99);
			if (r < 58) begin
				w = lookup_word(pick_type());
			end else if (r < 84) begin
				w = sample_word();
			end else if (r < 92) begin
				w = bounds_word();
			end else begin
				w     = noise_word();
				w.req = REQ_NONE;
			end
			send_word(w, 1'b0, none_res);
		end
		in_valid <= 1'b0;

		// drain; the timeout process catches a hang here
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: filelist.f
design/ppti_pkg.sv
design/ppti_mem.sv
design/ppti_interp.sv
design/pair_potential_table_interp.sv
tb/testbench.sv
